>>> design/itp_pkg.sv
// Shared types and constants of the interrupt controller table parser.
`timescale 1ns / 1ps
package itp_pkg;

	localparam int unsigned KEEP_BYTES = 12;
	localparam int unsigned KEEP_IDX_W = 4;
	localparam int unsigned CPU_CNT_W  = 9;
	localparam int unsigned IO_CNT_W   = 7;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = 2;
	localparam int unsigned FIFO_CNT_W = 3;

	localparam logic [31:0] ENTRY_START = 32'd44;
	localparam logic [29:0] LEN_WORD    = 30'd1;
	localparam logic [29:0] LADDR_WORD  = 30'd9;
	localparam logic [7:0]  MIN_ENTRY_LEN = 8'd2;
	localparam logic [7:0]  OVR_MIN_LEN   = 8'd12;
	localparam logic [7:0]  X2_MIN_LEN    = 8'd16;
	localparam logic [1:0]  ENABLE_FLAGS  = 2'b11;

	localparam logic [7:0] TYPE_LOCAL    = 8'd0;
	localparam logic [7:0] TYPE_IO       = 8'd1;
	localparam logic [7:0] TYPE_ADDR_OVR = 8'd5;
	localparam logic [7:0] TYPE_X2_LOCAL = 8'd9;

	typedef enum logic [1:0] {
		KIND_CPU     = 2'd0,
		KIND_IO      = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       record_kind;
		logic [7:0]  cpu_id;
		logic [31:0] io_ctrl_address;
		logic [31:0] io_ctrl_irq_base;
		logic [31:0] local_ctrl_address;
		logic [6:0]  cpus_found;
		logic [3:0]  io_ctrls_found;
		logic        final_record;
	} rec_t;

	typedef struct packed {
		logic [1:0] num;
		rec_t       rec0;
		rec_t       rec1;
	} fifo_push_t;

endpackage

>>> design/itp_stream_if.sv
// Stream channels for table bytes and parsed records.
`timescale 1ns / 1ps
interface itp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] table_byte;
	logic       end_of_table;

	modport source(output valid, output table_byte, output end_of_table, input ready);
	modport sink(input valid, input table_byte, input end_of_table, output ready);
endinterface

interface itp_rec_if;
	logic        valid;
	logic        ready;
	logic [1:0]  record_kind;
	logic [7:0]  cpu_id;
	logic [31:0] io_ctrl_address;
	logic [31:0] io_ctrl_irq_base;
	logic [31:0] local_ctrl_address;
	logic [6:0]  cpus_found;
	logic [3:0]  io_ctrls_found;
	logic        final_record;

	modport source(output valid, output record_kind, output cpu_id, output io_ctrl_address,
		output io_ctrl_irq_base, output local_ctrl_address, output cpus_found,
		output io_ctrls_found, output final_record, input ready);
	modport sink(input valid, input record_kind, input cpu_id, input io_ctrl_address,
		input io_ctrl_irq_base, input local_ctrl_address, input cpus_found,
		input io_ctrls_found, input final_record, output ready);
endinterface

>>> design/itp_rec_fifo.sv
// Small record queue taking up to two records per cycle and giving one.
`timescale 1ns / 1ps
module itp_rec_fifo import itp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fifo_push_t            push,
	input  logic                  pop,
	output rec_t                  head,
	output logic [FIFO_CNT_W-1:0] count
);

	rec_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.rec0;
		end
		if (push.num == 2'd2) begin
			mem_q[FIFO_PTR_W'(wr_ptr_q + 1'b1)] <= push.rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= FIFO_PTR_W'(wr_ptr_q + FIFO_PTR_W'(push.num));
			rd_ptr_q <= FIFO_PTR_W'(rd_ptr_q + FIFO_PTR_W'(pop));
			cnt_q    <= FIFO_CNT_W'(cnt_q + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop));
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

>>> design/interrupt_controller_table_parser.sv
// Top level: byte-wise walker of the interrupt controller description table.
// Path: a byte is registered at its transfer and processed once the record queue has room;
//   its records are written into that queue and offered on record_out from its head.
// Throughput: one byte per cycle while the queue has room for two records; a byte that yields
//   both an entry record and the summary pushes both into a four-record queue.
// Reset clears all control state; the summary record also returns the walker to reset.
`timescale 1ns / 1ps
module interrupt_controller_table_parser import itp_pkg::*; #(
	parameter int unsigned MAX_CPUS     = 64,
	parameter int unsigned MAX_IO_CTRLS = 8
) (
	input logic        clk,
	input logic        arst_n,
	itp_byte_if.sink   table_in,
	itp_rec_if.source  record_out
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       consume;

	logic [31:0]          pos_q;
	logic [31:0]          tlen_q;
	logic [7:0]           epos_q;
	logic [7:0]           elen_q;
	logic [7:0]           eb_q [KEEP_BYTES];
	logic [31:0]          laddr_q;
	logic [CPU_CNT_W-1:0] cpu_cnt_q;
	logic [IO_CNT_W-1:0]  io_cnt_q;
	logic                 stopped_q;

	logic [31:0]          pos_n;
	logic [31:0]          tlen_n;
	logic [7:0]           epos_n;
	logic [7:0]           elen_n;
	logic [7:0]           eb_n [KEEP_BYTES];
	logic [31:0]          laddr_n;
	logic [CPU_CNT_W-1:0] cpu_cnt_n;
	logic [IO_CNT_W-1:0]  io_cnt_n;
	logic                 stop_n;

	fifo_push_t            push;
	rec_t                  head;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic                  pop;

	assign consume        = valid_s1 && (fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign table_in.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (table_in.ready) begin
			valid_s1 <= table_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (table_in.valid && table_in.ready) begin
			byte_s1 <= table_in.table_byte;
			last_s1 <= table_in.end_of_table;
		end
	end

	always_comb begin
		logic        in_entry;
		logic        done;
		logic        has_rec;
		logic        cpu_ok;
		logic        io_ok;
		logic [7:0]  etype;
		logic [31:0] f4;
		logic [31:0] f8;
		rec_t        entry_rec;
		rec_t        summary;

		tlen_n    = tlen_q;
		laddr_n   = laddr_q;
		epos_n    = epos_q;
		elen_n    = elen_q;
		eb_n      = eb_q;
		stop_n    = stopped_q;
		cpu_cnt_n = cpu_cnt_q;
		io_cnt_n  = io_cnt_q;
		done      = 1'b0;
		has_rec   = 1'b0;
		entry_rec = '0;
		summary   = '0;

		pos_n    = (pos_q == '1) ? pos_q : 32'(pos_q + 32'd1);
		in_entry = (pos_q >= ENTRY_START) && (pos_q < tlen_q) && !stopped_q;

		for (int l = 0; l < 4; l++) begin
			if (pos_q[31:2] == LEN_WORD && pos_q[1:0] == 2'(l)) begin
				tlen_n[l*8 +: 8] = byte_s1;
			end
			if (pos_q[31:2] == LADDR_WORD && pos_q[1:0] == 2'(l)) begin
				laddr_n[l*8 +: 8] = byte_s1;
			end
		end

		if (in_entry) begin
			if (epos_q == 8'd0) begin
				for (int i = 0; i < KEEP_BYTES; i++) begin
					eb_n[i] = 8'd0;
				end
				eb_n[0] = byte_s1;
				epos_n  = 8'd1;
			end else if (epos_q == 8'd1) begin
				if (byte_s1 < MIN_ENTRY_LEN) begin
					stop_n = 1'b1;
					epos_n = 8'd0;
				end else begin
					eb_n[1] = byte_s1;
					elen_n  = byte_s1;
					epos_n  = 8'd2;
					done    = (byte_s1 == MIN_ENTRY_LEN);
				end
			end else begin
				if (epos_q < 8'(KEEP_BYTES)) begin
					eb_n[epos_q[KEEP_IDX_W-1:0]] = byte_s1;
				end
				epos_n = 8'(epos_q + 8'd1);
				done   = (epos_n == elen_q);
			end
		end

		etype  = eb_n[0];
		f4     = {eb_n[7], eb_n[6], eb_n[5], eb_n[4]};
		f8     = {eb_n[11], eb_n[10], eb_n[9], eb_n[8]};
		cpu_ok = cpu_cnt_q < CPU_CNT_W'(MAX_CPUS);
		io_ok  = io_cnt_q < IO_CNT_W'(MAX_IO_CTRLS);

		if (done) begin
			epos_n = 8'd0;
			unique case (etype)
				TYPE_LOCAL: begin
					if ((eb_n[4][1:0] & ENABLE_FLAGS) != 2'b00 && cpu_ok) begin
						has_rec              = 1'b1;
						entry_rec.record_kind = KIND_CPU;
						entry_rec.cpu_id      = eb_n[3];
						cpu_cnt_n            = CPU_CNT_W'(cpu_cnt_q + 1'b1);
					end
				end
				TYPE_IO: begin
					if (io_ok) begin
						has_rec                    = 1'b1;
						entry_rec.record_kind       = KIND_IO;
						entry_rec.io_ctrl_address   = f4;
						entry_rec.io_ctrl_irq_base  = f8;
						io_cnt_n                   = IO_CNT_W'(io_cnt_q + 1'b1);
					end
				end
				TYPE_ADDR_OVR: begin
					if (elen_n >= OVR_MIN_LEN) begin
						laddr_n = f4;
					end
				end
				TYPE_X2_LOCAL: begin
					if (elen_n >= X2_MIN_LEN && cpu_ok && (f8[1:0] & ENABLE_FLAGS) != 2'b00) begin
						has_rec              = 1'b1;
						entry_rec.record_kind = KIND_CPU;
						entry_rec.cpu_id      = eb_n[4];
						cpu_cnt_n            = CPU_CNT_W'(cpu_cnt_q + 1'b1);
					end
				end
				default: begin
				end
			endcase
		end

		summary.record_kind        = KIND_SUMMARY;
		summary.local_ctrl_address = laddr_n;
		summary.cpus_found         = cpu_cnt_n[6:0];
		summary.io_ctrls_found     = io_cnt_n[3:0];
		summary.final_record       = 1'b1;

		push.num  = consume ? (2'(has_rec) + 2'(last_s1)) : 2'd0;
		push.rec0 = has_rec ? entry_rec : summary;
		push.rec1 = summary;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			tlen_q    <= '0;
			epos_q    <= '0;
			elen_q    <= '0;
			laddr_q   <= '0;
			cpu_cnt_q <= '0;
			io_cnt_q  <= '0;
			stopped_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				pos_q     <= '0;
				tlen_q    <= '0;
				epos_q    <= '0;
				elen_q    <= '0;
				laddr_q   <= '0;
				cpu_cnt_q <= '0;
				io_cnt_q  <= '0;
				stopped_q <= 1'b0;
			end else begin
				pos_q     <= pos_n;
				tlen_q    <= tlen_n;
				epos_q    <= epos_n;
				elen_q    <= elen_n;
				laddr_q   <= laddr_n;
				cpu_cnt_q <= cpu_cnt_n;
				io_cnt_q  <= io_cnt_n;
				stopped_q <= stop_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			eb_q <= eb_n;
		end
	end

	assign pop = record_out.valid && record_out.ready;

	itp_rec_fifo u_rec_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (fifo_cnt)
	);

	assign record_out.valid              = (fifo_cnt != '0);
	assign record_out.record_kind        = head.record_kind;
	assign record_out.cpu_id             = head.cpu_id;
	assign record_out.io_ctrl_address    = head.io_ctrl_address;
	assign record_out.io_ctrl_irq_base   = head.io_ctrl_irq_base;
	assign record_out.local_ctrl_address = head.local_ctrl_address;
	assign record_out.cpus_found         = head.cpus_found;
	assign record_out.io_ctrls_found     = head.io_ctrls_found;
	assign record_out.final_record       = head.final_record;

`ifndef SYNTH
	a_summary_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> pos_q == '0 && cpu_cnt_q == '0 && io_cnt_q == '0)
		else $error("walker state not cleared after summary");

	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> epos_q == 8'd0)
		else $error("entry in progress after walk stop");

	a_cpu_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cpu_cnt_q <= CPU_CNT_W'(MAX_CPUS) && io_cnt_q <= IO_CNT_W'(MAX_IO_CTRLS))
		else $error("controller count beyond cap");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("record queue overflow");
`endif

endmodule

>>> dv/interrupt_controller_table_parser_test.sv
// Self-checking testbench of the interrupt controller table parser: directed and random tables.
`timescale 1ns / 1ps
module interrupt_controller_table_parser_test;
	import itp_pkg::*;

	localparam int unsigned CPU_CAP = 64;
	localparam int unsigned IO_CAP = 8;
	localparam int unsigned RANDOM_BYTES = 250;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;

	itp_byte_if byte_ch();
	itp_rec_if rec_ch();

	interrupt_controller_table_parser #(
		.MAX_CPUS(CPU_CAP),
		.MAX_IO_CTRLS(IO_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.table_in(byte_ch),
		.record_out(rec_ch)
	);

	// walker state
	logic [31:0] walk_pos;
	logic [31:0] walk_len;
	logic [31:0] walk_laddr;
	logic [7:0]  entry_at;
	logic [7:0]  entry_len;
	logic [7:0]  entry_buf [KEEP_BYTES];
	int unsigned cpus_seen;
	int unsigned ios_seen;
	bit          walk_stopped;

	rec_t        pending_records[$];
	logic [7:0]  table_image[$];

	int unsigned mismatches;
	int unsigned bytes_sent;
	int unsigned tables_sent;
	int unsigned records_checked[3];
	int unsigned cycle_count;
	int unsigned burst_left;
	bit          gaps_on;
	bit          hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_walker();
		walk_pos = '0;
		walk_len = '0;
		walk_laddr = '0;
		entry_at = '0;
		entry_len = '0;
		foreach (entry_buf[i]) entry_buf[i] = '0;
		cpus_seen = 0;
		ios_seen = 0;
		walk_stopped = 1'b0;
	endfunction

	function automatic logic [31:0] entry_word(input int at);
		return {entry_buf[at + 3], entry_buf[at + 2], entry_buf[at + 1], entry_buf[at]};
	endfunction

	function automatic void close_entry();
		rec_t r;
		r = '0;
		case (entry_buf[0])
			TYPE_LOCAL: if ((entry_buf[4][1:0] & ENABLE_FLAGS) != 0 && cpus_seen < CPU_CAP) begin
				cpus_seen++;
				r.record_kind = KIND_CPU;
				r.cpu_id = entry_buf[3];
				pending_records.push_back(r);
			end
			TYPE_IO: if (ios_seen < IO_CAP) begin
				ios_seen++;
				r.record_kind = KIND_IO;
				r.io_ctrl_address = entry_word(4);
				r.io_ctrl_irq_base = entry_word(8);
				pending_records.push_back(r);
			end
			TYPE_ADDR_OVR: if (entry_len >= OVR_MIN_LEN) begin
				walk_laddr = entry_word(4);
			end
			TYPE_X2_LOCAL: if (entry_len >= X2_MIN_LEN && cpus_seen < CPU_CAP &&
					(entry_buf[8][1:0] & ENABLE_FLAGS) != 0) begin
				cpus_seen++;
				r.record_kind = KIND_CPU;
				r.cpu_id = entry_buf[4];
				pending_records.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic last);
		rec_t r;
		bit done;
		done = 1'b0;
		if (walk_pos >= 4 && walk_pos < 8) begin
			walk_len[8 * (walk_pos - 4) +: 8] = b;
		end else if (walk_pos >= 36 && walk_pos < 40) begin
			walk_laddr[8 * (walk_pos - 36) +: 8] = b;
		end else if (walk_pos >= ENTRY_START && walk_pos < walk_len && !walk_stopped) begin
			if (entry_at == 0) begin
				foreach (entry_buf[i]) entry_buf[i] = '0;
				entry_buf[0] = b;
				entry_at = 8'd1;
			end else if (entry_at == 1) begin
				if (b < MIN_ENTRY_LEN) begin
					walk_stopped = 1'b1;
					entry_at = '0;
				end else begin
					entry_buf[1] = b;
					entry_len = b;
					entry_at = 8'd2;
					done = (b == MIN_ENTRY_LEN);
				end
			end else begin
				if (entry_at < KEEP_BYTES) entry_buf[entry_at[KEEP_IDX_W-1:0]] = b;
				entry_at = entry_at + 8'd1;
				done = (entry_at == entry_len);
			end
			if (done) begin
				close_entry();
				entry_at = '0;
			end
		end
		if (walk_pos != '1) walk_pos = walk_pos + 32'd1;
		if (last) begin
			r = '0;
			r.record_kind = KIND_SUMMARY;
			r.local_ctrl_address = walk_laddr;
			r.cpus_found = cpus_seen[6:0];
			r.io_ctrls_found = ios_seen[3:0];
			r.final_record = 1'b1;
			pending_records.push_back(r);
			reset_walker();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : record_check
		rec_t want;
		if (arst_n === 1'b1 && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) begin
			if (pending_records.size() == 0) begin
				report_mismatch("record with none expected", 32'(rec_ch.record_kind), '0);
			end else begin
				want = pending_records.pop_front();
				records_checked[want.record_kind]++;
				if (rec_ch.record_kind !== want.record_kind)
					report_mismatch("record_kind", 32'(rec_ch.record_kind),
						32'(want.record_kind));
				if (rec_ch.cpu_id !== want.cpu_id)
					report_mismatch("cpu_id", 32'(rec_ch.cpu_id), 32'(want.cpu_id));
				if (rec_ch.io_ctrl_address !== want.io_ctrl_address)
					report_mismatch("io_ctrl_address", rec_ch.io_ctrl_address,
						want.io_ctrl_address);
				if (rec_ch.io_ctrl_irq_base !== want.io_ctrl_irq_base)
					report_mismatch("io_ctrl_irq_base", rec_ch.io_ctrl_irq_base,
						want.io_ctrl_irq_base);
				if (rec_ch.local_ctrl_address !== want.local_ctrl_address)
					report_mismatch("local_ctrl_address", rec_ch.local_ctrl_address,
						want.local_ctrl_address);
				if (rec_ch.cpus_found !== want.cpus_found)
					report_mismatch("cpus_found", 32'(rec_ch.cpus_found),
						32'(want.cpus_found));
				if (rec_ch.io_ctrls_found !== want.io_ctrls_found)
					report_mismatch("io_ctrls_found", 32'(rec_ch.io_ctrls_found),
						32'(want.io_ctrls_found));
				if (rec_ch.final_record !== want.final_record)
					report_mismatch("final_record", 32'(rec_ch.final_record),
						32'(want.final_record));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d records outstanding",
				cycle_count, pending_records.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : receiver
		int mode;
		int stretch;
		int phase;
		mode = 0;
		stretch = 0;
		phase = 0;
		rec_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rec_ch.ready <= 1'b0;
				for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(16, 128);
				end
				stretch--;
				phase++;
				case (mode)
					0: rec_ch.ready <= 1'b1;
					1: rec_ch.ready <= 1'($urandom_range(0, 1));
					2: rec_ch.ready <= (phase % 5) != 0;
					default: rec_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 9);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0) burst_left--;
		byte_ch.valid <= 1'b1;
		byte_ch.table_byte <= b;
		byte_ch.end_of_table <= last;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		parse_byte(b, last);
		bytes_sent++;
	endtask

	task automatic wait_for_records();
		byte_ch.valid <= 1'b0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void begin_table(input logic [31:0] laddr);
		table_image.delete();
		for (int i = 0; i < ENTRY_START; i++) table_image.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) table_image[36 + i] = laddr[8 * i +: 8];
	endfunction

	function automatic void add_entry(input logic [7:0] kind, input logic [7:0] len,
			input logic [31:0] w4, input logic [31:0] w8);
		logic [7:0] b;
		table_image.push_back(kind);
		table_image.push_back(len);
		for (int i = 2; i < len; i++) begin
			if (i >= 4 && i < 8) b = w4[8 * (i - 4) +: 8];
			else if (i >= 8 && i < 12) b = w8[8 * (i - 8) +: 8];
			else b = 8'($urandom);
			table_image.push_back(b);
		end
	endfunction

	task automatic send_table(input logic [31:0] declared, input int count);
		for (int i = 0; i < 4; i++) table_image[4 + i] = declared[8 * i +: 8];
		for (int i = 0; i < count; i++) send_byte(table_image[i], i == count - 1);
		tables_sent++;
	endtask

	task automatic test_short_tables();
		begin_table(32'hFFFF_FFFF);
		send_table(32'd44, 1);
		begin_table(32'h1234_5678);
		send_table(32'd44, 6);
		begin_table(32'hA5A5_5A5A);
		send_table(32'd44, 38);
		begin_table(32'hFFFF_FFFF);
		send_table(32'd44, 44);
		begin_table(32'h0);
		send_table(32'hFFFF_FFFF, 44);
		wait_for_records();
	endtask

	task automatic test_entry_kinds();
		begin_table(32'hFEE0_0000);
		add_entry(TYPE_LOCAL, 8'd8, 32'h01, 32'h0);
		add_entry(TYPE_LOCAL, 8'd8, 32'h02, 32'h0);
		add_entry(TYPE_LOCAL, 8'd8, 32'hFC, 32'h0);
		add_entry(TYPE_LOCAL, 8'd5, 32'h03, 32'h0);
		add_entry(TYPE_LOCAL, 8'd2, 32'h03, 32'h0);
		add_entry(TYPE_IO, 8'd12, 32'hFFFF_FFFF, 32'h0);
		add_entry(TYPE_IO, 8'd12, 32'h0, 32'hFFFF_FFFF);
		add_entry(TYPE_IO, 8'd6, 32'hFEC0_0000, 32'h18);
		add_entry(TYPE_ADDR_OVR, 8'd11, 32'h1111_1111, 32'h0);
		add_entry(TYPE_ADDR_OVR, 8'd12, 32'hDEAD_BEEF, 32'h0);
		add_entry(TYPE_X2_LOCAL, 8'd16, 32'h0000_01FF, 32'h1);
		add_entry(TYPE_X2_LOCAL, 8'd16, 32'h7, 32'hFFFF_FFFC);
		add_entry(TYPE_X2_LOCAL, 8'd15, 32'h8, 32'h3);
		add_entry(TYPE_X2_LOCAL, 8'd20, 32'h9, 32'h2);
		add_entry(8'hFF, 8'd40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_entry(8'h7F, 8'd2, 32'h0, 32'h0);
		add_entry(TYPE_ADDR_OVR, 8'd16, 32'h8765_4321, 32'hFFFF_FFFF);
		add_entry(TYPE_IO, 8'd12, $urandom, $urandom);
		send_table(table_image.size(), table_image.size());
		wait_for_records();
	endtask

	task automatic test_length_limits();
		begin_table(32'h1);
		add_entry(TYPE_LOCAL, 8'd8, 32'h1, 32'h0);
		add_entry(TYPE_LOCAL, 8'd0, 32'h0, 32'h0);
		add_entry(TYPE_LOCAL, 8'd8, 32'h1, 32'h0);
		send_table(table_image.size(), table_image.size());
		begin_table(32'h2);
		add_entry(TYPE_IO, 8'd1, 32'h0, 32'h0);
		add_entry(TYPE_IO, 8'd12, 32'h5, 32'h6);
		send_table(table_image.size(), table_image.size());
		begin_table(32'h3);
		add_entry(TYPE_LOCAL, 8'd8, 32'h2, 32'h0);
		add_entry(TYPE_IO, 8'd12, 32'hFEC0_0000, 32'h0);
		add_entry(TYPE_LOCAL, 8'd8, 32'h2, 32'h0);
		send_table(32'd58, table_image.size());
		begin_table(32'h4);
		add_entry(TYPE_LOCAL, 8'd8, 32'h1, 32'h0);
		add_entry(TYPE_IO, 8'd12, 32'h1234_5678, 32'h20);
		send_table(table_image.size() + 20, table_image.size() - 5);
		begin_table(32'h5);
		add_entry(TYPE_LOCAL, 8'd8, 32'h1, 32'h0);
		send_table(32'd10, table_image.size());
		wait_for_records();
	endtask

	task automatic test_cpu_and_io_caps();
		begin_table($urandom);
		for (int i = 0; i < CPU_CAP + 2; i++) add_entry(TYPE_LOCAL, 8'd5, 32'h1, 32'h0);
		for (int i = 0; i < IO_CAP + 2; i++) add_entry(TYPE_IO, 8'd2, 32'h0, 32'h0);
		add_entry(TYPE_X2_LOCAL, 8'd16, $urandom, 32'h3);
		add_entry(TYPE_X2_LOCAL, 8'd16, $urandom, 32'h1);
		send_table(table_image.size(), table_image.size());
		wait_for_records();
	endtask

	task automatic test_back_pressure();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		begin_table($urandom);
		for (int i = 0; i < 6; i++) add_entry(TYPE_LOCAL, 8'd6, 32'h3, 32'h0);
		add_entry(TYPE_IO, 8'd12, $urandom, $urandom);
		send_table(table_image.size(), table_image.size());
		wait_for_records();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_tables();
		int unsigned start;
		int entries;
		int sel;
		int count;
		logic [31:0] declared;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			begin_table($urandom);
			entries = $urandom_range(1, 8);
			for (int i = 0; i < entries; i++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4:
						add_entry(TYPE_LOCAL, ($urandom_range(0, 3) != 0) ? 8'd8 :
							8'($urandom_range(2, 10)), $urandom, $urandom);
					5, 6, 7, 8:
						add_entry(TYPE_IO, ($urandom_range(0, 3) != 0) ? 8'd12 :
							8'($urandom_range(2, 16)), $urandom, $urandom);
					9, 10:
						add_entry(TYPE_ADDR_OVR, 8'($urandom_range(10, 16)), $urandom, $urandom);
					11, 12, 13:
						add_entry(TYPE_X2_LOCAL, ($urandom_range(0, 2) != 0) ? 8'd16 :
							8'($urandom_range(2, 24)), $urandom, $urandom);
					14, 15, 16:
						add_entry(8'($urandom), 8'($urandom_range(2, 40)), $urandom, $urandom);
					17:
						add_entry(8'($urandom_range(0, 9)), 8'($urandom_range(0, 1)), 32'h0,
							32'h0);
					default:
						add_entry(8'($urandom), 8'($urandom_range(2, 60)), $urandom, $urandom);
				endcase
			end
			declared = table_image.size();
			count = table_image.size();
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				count = $urandom_range(1, table_image.size());
			end else if (sel <= 2) begin
				declared = $urandom_range(ENTRY_START, table_image.size());
			end else if (sel <= 4) begin
				declared = table_image.size() + $urandom_range(1, 30);
				count = $urandom_range(ENTRY_START + 1, table_image.size());
			end else if (sel == 5) begin
				declared = $urandom;
			end
			send_table(declared, count);
			if ($urandom_range(0, 3) == 0) wait_for_records();
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		byte_ch.valid <= 1'b0;
		byte_ch.table_byte <= '0;
		byte_ch.end_of_table <= 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		bytes_sent = 0;
		tables_sent = 0;
		cycle_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_request = 1'b0;
		foreach (records_checked[i]) records_checked[i] = 0;
		reset_walker();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_tables();
		test_entry_kinds();
		test_length_limits();
		test_cpu_and_io_caps();
		test_back_pressure();
		test_random_tables();

		wait_for_records();
		$display("Sent %0d tables, %0d bytes; checked %0d CPU, %0d I/O and %0d summary records",
			tables_sent, bytes_sent, records_checked[KIND_CPU], records_checked[KIND_IO],
			records_checked[KIND_SUMMARY]);
		$display("Covered short and cut tables, walk stops, caps and output back-pressure");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
